FILE: src/slrf_pkg.sv
// Shared types and constants of the simple linear regression fit core.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package slrf_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int X_W       = 32;
    localparam int SUM_W     = 38;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 66;
    localparam int ACC_W     = 72;
    localparam int DIVN_W    = 88;
    localparam int DIVD_W    = 72;
    localparam int WIDE_W    = 52;
    localparam int STAT_W    = 3;
    localparam int FRAC_W    = 16;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 3'd0,
        ST_FEW  = 3'd1,
        ST_FLAT = 3'd2,
        ST_SAT  = 3'd3,
        ST_DROP = 3'd4
    } fit_status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET_FEW,
        OP_MX,
        OP_MY,
        OP_P1_XX,
        OP_P1_XY,
        OP_P1_ACC,
        OP_SET_FLAT,
        OP_SLOPE,
        OP_ICPT_MUL,
        OP_ICPT,
        OP_MUL_X,
        OP_FIT,
        OP_RES,
        OP_SQ,
        OP_SSR_ACC,
        OP_MSE,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   fire;
        logic   div_start;
        logic   track_sat;
        logic   idx_clr;
        logic   idx_inc;
        logic   run_clr;
    } cmd_t;

    typedef struct packed {
        logic few;
        logic flat;
        logic last_idx;
        logic div_busy;
        logic div_done;
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

FILE: src/slrf_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module slrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: src/slrf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependency.
`default_nettype none
module slrf_div #(
    parameter int N_W = 88,
    parameter int D_W = 72
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output logic                busy,
    output logic                done,
    output logic      [N_W-1:0] quotient
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [D_W-1:0]   rem_reg;
    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   d_reg;
    logic [D_W:0]     shifted;
    logic [D_W:0]     diff;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[N_W-1]};
    assign diff    = shifted - {1'b0, d_reg};
    assign ge      = shifted >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(N_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
            quo_reg <= {quo_reg[N_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_reg)
        else $error("divider started while busy");
endmodule
`default_nettype wire

FILE: src/slrf_datapath.sv
// Datapath: point buffers, sums, shared multiplier, divider and output register.
// Depends on slrf_pkg, slrf_ram and slrf_div.
`default_nettype none
module slrf_datapath #(
    parameter int DEPTH = slrf_pkg::DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire slrf_pkg::cmd_t      cmd,
    output slrf_pkg::stat_t          st,
    input  wire logic signed [31:0]  x_value,
    input  wire logic signed [31:0]  y_value,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic signed [31:0]       fitted_value,
    output logic signed [31:0]       residual,
    output logic signed [31:0]       intercept,
    output logic signed [31:0]       slope,
    output logic        [31:0]       mean_sq_error,
    output logic        [2:0]        fit_status,
    output logic                     last_result
);
    import slrf_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    logic [CNT_W-1:0]         count_reg, idx_reg;
    logic signed [SUM_W-1:0]  xsum_reg, ysum_reg;
    logic                     ovf_reg, sat_reg, outv_reg;
    fit_status_t              status_reg;
    logic signed [X_W-1:0]    mx_reg, my_reg, slope_reg, icpt_reg, f_reg, r_reg;
    logic [X_W-1:0]           mse_reg;
    logic signed [ACC_W-1:0]  sxx_reg, sxy_reg, ssr_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [X_W-1:0]    o_fit_reg, o_res_reg, o_icpt_reg, o_slope_reg;
    logic [X_W-1:0]           o_mse_reg;
    fit_status_t              o_stat_reg;
    logic                     o_last_reg;

    logic signed [X_W-1:0]    x_q, y_q;
    logic                     full, we;
    logic signed [MUL_W-1:0]  dx, dy, mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [ACC_W-1:0]  prod_ext;
    logic                     div_start, div_busy, div_done;
    logic [DIVN_W-1:0]        div_n, quo;
    logic [DIVD_W-1:0]        div_d;
    logic [SUM_W-1:0]         xmag, ymag;
    logic [ACC_W-1:0]         sxy_mag;
    logic                     sxy_neg, slope_over, mse_over;
    logic [X_W:0]             slope_lim;
    logic signed [X_W-1:0]    slope_val, mean_q;
    logic signed [WIDE_W-1:0] prod_sh, icpt_w, fit_w, res_w;
    logic [X_W:0]             icpt_s, fit_s, res_s;
    logic                     zero_out, last_idx;

    function automatic logic [X_W:0] sat32(input logic signed [WIDE_W-1:0] v);
        if (v > WIDE_W'(64'sh7FFFFFFF))
            return {1'b1, 32'h7FFFFFFF};
        else if (v < -WIDE_W'(64'sh80000000))
            return {1'b1, 32'h80000000};
        else
            return {1'b0, v[X_W-1:0]};
    endfunction

    assign full = count_reg == CNT_W'(DEPTH);
    assign we   = cmd.fire && !full;

    slrf_ram #(.WIDTH(X_W), .DEPTH(DEPTH)) u_xram (
        .clk(clk), .we(we), .waddr(count_reg[ADDR_W-1:0]), .wdata(x_value),
        .raddr(idx_reg[ADDR_W-1:0]), .rdata(x_q)
    );
    slrf_ram #(.WIDTH(X_W), .DEPTH(DEPTH)) u_yram (
        .clk(clk), .we(we), .waddr(count_reg[ADDR_W-1:0]), .wdata(y_value),
        .raddr(idx_reg[ADDR_W-1:0]), .rdata(y_q)
    );

    assign xmag    = xsum_reg[SUM_W-1] ? SUM_W'(-xsum_reg) : SUM_W'(xsum_reg);
    assign ymag    = ysum_reg[SUM_W-1] ? SUM_W'(-ysum_reg) : SUM_W'(ysum_reg);
    assign sxy_neg = sxy_reg[ACC_W-1];
    assign sxy_mag = sxy_neg ? ACC_W'(-sxy_reg) : ACC_W'(sxy_reg);

    always_comb
    begin
        div_n = '0;
        div_d = '0;
        unique case (cmd.op)
            OP_MX:
            begin
                div_n = DIVN_W'(xmag);
                div_d = DIVD_W'(count_reg);
            end
            OP_MY:
            begin
                div_n = DIVN_W'(ymag);
                div_d = DIVD_W'(count_reg);
            end
            OP_SLOPE:
            begin
                div_n = DIVN_W'(sxy_mag) << FRAC_W;
                div_d = DIVD_W'(sxx_reg);
            end
            OP_MSE:
            begin
                div_n = DIVN_W'(ssr_reg);
                div_d = DIVD_W'(count_reg - CNT_W'(2)) << FRAC_W;
            end
            default:
            begin
                div_n = '0;
                div_d = '0;
            end
        endcase
    end

    assign div_start = cmd.div_start;

    slrf_div #(.N_W(DIVN_W), .D_W(DIVD_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n), .divisor(div_d),
        .busy(div_busy), .done(div_done), .quotient(quo)
    );

    assign dx = MUL_W'(x_q) - MUL_W'(mx_reg);
    assign dy = MUL_W'(y_q) - MUL_W'(my_reg);

    always_comb
    begin
        unique case (cmd.op)
            OP_P1_XX:
            begin
                mul_a = dx;
                mul_b = dx;
            end
            OP_P1_XY:
            begin
                mul_a = dx;
                mul_b = dy;
            end
            OP_ICPT_MUL:
            begin
                mul_a = MUL_W'(slope_reg);
                mul_b = MUL_W'(mx_reg);
            end
            OP_MUL_X:
            begin
                mul_a = MUL_W'(slope_reg);
                mul_b = MUL_W'(x_q);
            end
            OP_SQ:
            begin
                mul_a = MUL_W'(r_reg);
                mul_b = MUL_W'(r_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = ACC_W'(prod_reg);

    assign mean_q     = (cmd.op == OP_MX ? xsum_reg[SUM_W-1] : ysum_reg[SUM_W-1])
                        ? -quo[X_W-1:0] : quo[X_W-1:0];
    assign slope_lim  = sxy_neg ? {1'b0, 32'h80000000} : {1'b0, 32'h7FFFFFFF};
    assign slope_over = (|quo[DIVN_W-1:X_W]) || ({1'b0, quo[X_W-1:0]} > slope_lim);
    assign slope_val  = slope_over ? slope_lim[X_W-1:0]
                        : (sxy_neg ? -quo[X_W-1:0] : quo[X_W-1:0]);
    assign mse_over   = |quo[DIVN_W-1:X_W];

    assign prod_sh = WIDE_W'(signed'(prod_reg[PROD_W-1:FRAC_W]));
    assign icpt_w  = WIDE_W'(my_reg) - prod_sh;
    assign fit_w   = WIDE_W'(icpt_reg) + prod_sh;
    assign res_w   = WIDE_W'(y_q) - WIDE_W'(f_reg);
    assign icpt_s  = sat32(icpt_w);
    assign fit_s   = sat32(fit_w);
    assign res_s   = sat32(res_w);

    assign zero_out = status_reg == ST_FEW || status_reg == ST_FLAT;
    assign last_idx = idx_reg == count_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            xsum_reg   <= '0;
            ysum_reg   <= '0;
            ovf_reg    <= 1'b0;
            sat_reg    <= 1'b0;
            sxx_reg    <= '0;
            sxy_reg    <= '0;
            ssr_reg    <= '0;
            status_reg <= ST_OK;
            outv_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.fire)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    xsum_reg  <= xsum_reg + SUM_W'(x_value);
                    ysum_reg  <= ysum_reg + SUM_W'(y_value);
                end
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            unique case (cmd.op)
                OP_SET_FEW:  status_reg <= ST_FEW;
                OP_SET_FLAT: status_reg <= ST_FLAT;
                OP_P1_XY:    sxx_reg    <= sxx_reg + prod_ext;
                OP_P1_ACC:   sxy_reg    <= sxy_reg + prod_ext;
                OP_SSR_ACC:  ssr_reg    <= ssr_reg + prod_ext;
                OP_SLOPE:
                begin
                    if (div_done && slope_over)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                OP_ICPT:
                begin
                    if (icpt_s[X_W])
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                OP_FIT:
                begin
                    if (cmd.track_sat && fit_s[X_W])
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                OP_RES:
                begin
                    if (cmd.track_sat && res_s[X_W])
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                OP_MSE:
                begin
                    if (div_done)
                    begin
                        status_reg <= (sat_reg || mse_over) ? ST_SAT
                                      : (ovf_reg ? ST_DROP : ST_OK);
                    end
                end
                default:
                begin
                end
            endcase
            if (cmd.op == OP_OUT)
            begin
                outv_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                outv_reg <= 1'b0;
            end
            if (cmd.run_clr)
            begin
                count_reg <= '0;
                xsum_reg  <= '0;
                ysum_reg  <= '0;
                ovf_reg   <= 1'b0;
                sat_reg   <= 1'b0;
                sxx_reg   <= '0;
                sxy_reg   <= '0;
                ssr_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((cmd.op == OP_MX) && div_done)
        begin
            mx_reg <= mean_q;
        end
        if ((cmd.op == OP_MY) && div_done)
        begin
            my_reg <= mean_q;
        end
        if ((cmd.op == OP_SLOPE) && div_done)
        begin
            slope_reg <= slope_val;
        end
        if ((cmd.op == OP_MSE) && div_done)
        begin
            mse_reg <= mse_over ? 32'hFFFFFFFF : quo[X_W-1:0];
        end
        if (cmd.op == OP_P1_XX || cmd.op == OP_P1_XY || cmd.op == OP_ICPT_MUL
            || cmd.op == OP_MUL_X || cmd.op == OP_SQ)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.op == OP_ICPT)
        begin
            icpt_reg <= icpt_s[X_W-1:0];
        end
        if (cmd.op == OP_FIT)
        begin
            f_reg <= fit_s[X_W-1:0];
        end
        if (cmd.op == OP_RES)
        begin
            r_reg <= res_s[X_W-1:0];
        end
        if (cmd.op == OP_OUT)
        begin
            o_fit_reg   <= zero_out ? '0 : f_reg;
            o_res_reg   <= zero_out ? '0 : r_reg;
            o_icpt_reg  <= zero_out ? '0 : icpt_reg;
            o_slope_reg <= zero_out ? '0 : slope_reg;
            o_mse_reg   <= (zero_out || !last_idx) ? '0 : mse_reg;
            o_stat_reg  <= status_reg;
            o_last_reg  <= last_idx;
        end
    end

    assign st.few      = count_reg < CNT_W'(3);
    assign st.flat     = sxx_reg == '0;
    assign st.last_idx = last_idx;
    assign st.div_busy = div_busy;
    assign st.div_done = div_done;
    assign st.out_busy = outv_reg && !out_ready;

    assign out_valid     = outv_reg;
    assign fitted_value  = o_fit_reg;
    assign residual      = o_res_reg;
    assign intercept     = o_icpt_reg;
    assign slope         = o_slope_reg;
    assign mean_sq_error = o_mse_reg;
    assign fit_status    = o_stat_reg;
    assign last_result   = o_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("point count above buffer depth");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_OUT |-> !outv_reg || out_ready)
        else $error("pending result overwritten");
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_clr |-> cmd.op == OP_OUT && last_idx)
        else $error("run cleared before final result");
endmodule
`default_nettype wire

FILE: src/slrf_ctrl.sv
// Controller state machine: sequences load, means, sums, slope, residuals and emit.
// Depends on slrf_pkg.
`default_nettype none
module slrf_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_last,
    output logic                 in_ready,
    input  wire slrf_pkg::stat_t st,
    output slrf_pkg::cmd_t       cmd
);
    import slrf_pkg::*;

    typedef enum logic [22:0] {
        S_LOAD     = 23'd1 << 0,
        S_MX       = 23'd1 << 1,
        S_MY       = 23'd1 << 2,
        S_P1_RD    = 23'd1 << 3,
        S_P1_XX    = 23'd1 << 4,
        S_P1_XY    = 23'd1 << 5,
        S_P1_ACC   = 23'd1 << 6,
        S_CHECK    = 23'd1 << 7,
        S_SLOPE    = 23'd1 << 8,
        S_ICPT_MUL = 23'd1 << 9,
        S_ICPT     = 23'd1 << 10,
        S_P2_RD    = 23'd1 << 11,
        S_P2_MUL   = 23'd1 << 12,
        S_P2_FIT   = 23'd1 << 13,
        S_P2_RES   = 23'd1 << 14,
        S_P2_SQ    = 23'd1 << 15,
        S_P2_ACC   = 23'd1 << 16,
        S_MSE      = 23'd1 << 17,
        S_E_RD     = 23'd1 << 18,
        S_E_MUL    = 23'd1 << 19,
        S_E_FIT    = 23'd1 << 20,
        S_E_RES    = 23'd1 << 21,
        S_E_OUT    = 23'd1 << 22
    } state_t;

    state_t state_reg, state_next;
    logic   div_go;

    assign in_ready = state_reg == S_LOAD;
    assign div_go   = !st.div_busy && !st.div_done;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{op: OP_NONE, default: 1'b0};
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.op   = OP_LOAD;
                cmd.fire = in_valid;
                if (in_valid && in_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_MX;
                end
            end
            S_MX:
            begin
                if (st.few)
                begin
                    cmd.op     = OP_SET_FEW;
                    state_next = S_E_RD;
                end
                else
                begin
                    cmd.op        = OP_MX;
                    cmd.div_start = div_go;
                    if (st.div_done)
                    begin
                        state_next = S_MY;
                    end
                end
            end
            S_MY:
            begin
                cmd.op        = OP_MY;
                cmd.div_start = div_go;
                if (st.div_done)
                begin
                    state_next = S_P1_RD;
                end
            end
            S_P1_RD: state_next = S_P1_XX;
            S_P1_XX:
            begin
                cmd.op     = OP_P1_XX;
                state_next = S_P1_XY;
            end
            S_P1_XY:
            begin
                cmd.op     = OP_P1_XY;
                state_next = S_P1_ACC;
            end
            S_P1_ACC:
            begin
                cmd.op = OP_P1_ACC;
                if (st.last_idx)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_CHECK;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_P1_RD;
                end
            end
            S_CHECK:
            begin
                if (st.flat)
                begin
                    cmd.op     = OP_SET_FLAT;
                    state_next = S_E_RD;
                end
                else
                begin
                    state_next = S_SLOPE;
                end
            end
            S_SLOPE:
            begin
                cmd.op        = OP_SLOPE;
                cmd.div_start = div_go;
                if (st.div_done)
                begin
                    state_next = S_ICPT_MUL;
                end
            end
            S_ICPT_MUL:
            begin
                cmd.op     = OP_ICPT_MUL;
                state_next = S_ICPT;
            end
            S_ICPT:
            begin
                cmd.op     = OP_ICPT;
                state_next = S_P2_RD;
            end
            S_P2_RD: state_next = S_P2_MUL;
            S_P2_MUL:
            begin
                cmd.op     = OP_MUL_X;
                state_next = S_P2_FIT;
            end
            S_P2_FIT:
            begin
                cmd.op        = OP_FIT;
                cmd.track_sat = 1'b1;
                state_next    = S_P2_RES;
            end
            S_P2_RES:
            begin
                cmd.op        = OP_RES;
                cmd.track_sat = 1'b1;
                state_next    = S_P2_SQ;
            end
            S_P2_SQ:
            begin
                cmd.op     = OP_SQ;
                state_next = S_P2_ACC;
            end
            S_P2_ACC:
            begin
                cmd.op = OP_SSR_ACC;
                if (st.last_idx)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_MSE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_P2_RD;
                end
            end
            S_MSE:
            begin
                cmd.op        = OP_MSE;
                cmd.div_start = div_go;
                if (st.div_done)
                begin
                    state_next = S_E_RD;
                end
            end
            S_E_RD: state_next = S_E_MUL;
            S_E_MUL:
            begin
                cmd.op     = OP_MUL_X;
                state_next = S_E_FIT;
            end
            S_E_FIT:
            begin
                cmd.op     = OP_FIT;
                state_next = S_E_RES;
            end
            S_E_RES:
            begin
                cmd.op     = OP_RES;
                state_next = S_E_OUT;
            end
            S_E_OUT:
            begin
                if (!st.out_busy)
                begin
                    cmd.op = OP_OUT;
                    if (st.last_idx)
                    begin
                        cmd.run_clr = 1'b1;
                        cmd.idx_clr = 1'b1;
                        state_next  = S_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_E_RD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

FILE: src/simple_linear_regression_fit_core.sv
// Top level of the simple linear regression fit core.
// Depends on slrf_pkg, slrf_ctrl and slrf_datapath.
//
//  channel  | direction | signals
//  s_axis   | in        | tvalid, tready, tdata {y_value, x_value}, tlast last_point
//  m_axis   | out       | tvalid, tready, tdata {mse, slope, intercept, residual, fitted},
//           |           | tuser fit_status, tlast last_result
//
// Points load at one per cycle. After the last point the fit runs the bit-serial
// divider four times (two means, slope, mse), makes a first and a second pass over
// the points through the shared multiplier, and emits one result per point; a set
// with too few points or a flat x skips straight to the emit pass.
// Input is not accepted from the last point until the final result is loaded.
// A stalled m_axis holds its result; reset needs no clearing pass.
`default_nettype none
module simple_linear_regression_fit_core #(
    parameter int DEPTH = slrf_pkg::DEPTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,   // x_value[31:0], y_value[63:32]
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [159:0] m_axis_tdata,   // fitted, residual, intercept, slope, mse
    output logic      [2:0]   m_axis_tuser,   // fit_status[2:0]
    output logic              m_axis_tlast
);
    import slrf_pkg::*;

    cmd_t               cmd;
    stat_t              st;
    logic signed [31:0] fitted_value, residual, intercept, slope;
    logic        [31:0] mean_sq_error;

    slrf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_last(s_axis_tlast),
        .in_ready(s_axis_tready), .st(st), .cmd(cmd)
    );

    slrf_datapath #(.DEPTH(DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .x_value(s_axis_tdata[31:0]), .y_value(s_axis_tdata[63:32]),
        .out_ready(m_axis_tready), .out_valid(m_axis_tvalid),
        .fitted_value(fitted_value), .residual(residual), .intercept(intercept),
        .slope(slope), .mean_sq_error(mean_sq_error), .fit_status(m_axis_tuser),
        .last_result(m_axis_tlast)
    );

    assign m_axis_tdata = {mean_sq_error, slope, intercept, residual, fitted_value};
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for simple_linear_regression_fit_core.
// Streams (x, y) point sets, predicts every fit result in exact arithmetic
// and compares each m_axis transaction field by field. Depends on slrf_pkg.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import slrf_pkg::*;

    localparam int NPTS       = 64;
    localparam int IDLE_LIMIT = 8000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
    } point_t;

    typedef struct {
        logic [31:0] fitted;
        logic [31:0] residual;
        logic [31:0] icpt;
        logic [31:0] slope;
        logic [31:0] mse;
        fit_status_t status;
        logic        last;
    } fit_out_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    point_t   pending_points[$];
    fit_out_t expected_fits[$];
    longint   set_x[$];
    longint   set_y[$];
    bit       set_dropped;
    bit       clip_hit;
    bit       idle_on;
    bit       in_taken;
    bit       out_taken;
    int       send_gap;
    int       recv_stall;
    int       mismatches;
    int       idle_cycles;
    int       points_sent;
    int       fits_checked;
    int       sets_closed;

    simple_linear_regression_fit_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // x_value[31:0], y_value[63:32]
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // fitted, residual, intercept, slope, mse
        .m_axis_tuser  (m_axis_tuser),   // fit_status[2:0]
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) begin
            clip_hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clip_hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    task automatic close_set();
        int                  n;
        longint              sx;
        longint              sy;
        longint              mx;
        longint              my;
        longint              slope;
        longint              icpt;
        longint              f;
        longint              r;
        logic signed [127:0] dx;
        logic signed [127:0] dy;
        logic signed [127:0] sxx;
        logic signed [127:0] sxy;
        logic signed [127:0] ssr;
        logic signed [127:0] wr;
        logic        [127:0] mag;
        logic        [127:0] q;
        logic        [127:0] lim;
        logic        [31:0]  mse;
        bit                  neg;
        fit_status_t         st;
        fit_out_t            e;
        n = set_x.size();
        sx = 0; sy = 0; sxx = 0; sxy = 0; ssr = 0;
        slope = 0; icpt = 0; mse = 0;
        clip_hit = 1'b0;
        foreach (set_x[i])
        begin
            sx += set_x[i];
            sy += set_y[i];
        end
        if (n < 3)
        begin
            st = ST_FEW;
        end
        else
        begin
            mx = sx / n;
            my = sy / n;
            foreach (set_x[i])
            begin
                dx = set_x[i] - mx;
                dy = set_y[i] - my;
                sxx += dx * dx;
                sxy += dx * dy;
            end
            if (sxx == 0)
            begin
                st = ST_FLAT;
            end
            else
            begin
                neg = sxy < 0;
                mag = neg ? -sxy : sxy;
                lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
                q = (mag << 16) / 128'(sxx);
                if (q > lim)
                begin
                    clip_hit = 1'b1;
                    q = lim;
                end
                slope = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
                icpt = clip32(my - ((slope * mx) >>> 16));
                foreach (set_x[i])
                begin
                    f = clip32(icpt + ((slope * set_x[i]) >>> 16));
                    r = clip32(set_y[i] - f);
                    wr = r;
                    ssr += wr * wr;
                end
                q = 128'(ssr) / (128'(n - 2) << 16);
                if (q > 128'hffff_ffff)
                begin
                    clip_hit = 1'b1;
                    mse = 32'hffff_ffff;
                end
                else
                begin
                    mse = q[31:0];
                end
                st = clip_hit ? ST_SAT : (set_dropped ? ST_DROP : ST_OK);
            end
        end
        foreach (set_x[i])
        begin
            e = '{fitted: '0, residual: '0, icpt: '0, slope: '0, mse: '0,
                  status: st, last: 1'b0};
            e.last = (i == n - 1);
            if (st != ST_FEW && st != ST_FLAT)
            begin
                f = clip32(icpt + ((slope * set_x[i]) >>> 16));
                r = clip32(set_y[i] - f);
                e.fitted = f[31:0];
                e.residual = r[31:0];
                e.icpt = icpt[31:0];
                e.slope = slope[31:0];
                e.mse = e.last ? mse : 32'd0;
            end
            expected_fits = {expected_fits, e};
        end
        set_x.delete();
        set_y.delete();
        set_dropped = 1'b0;
        sets_closed++;
    endtask

    task automatic add_point(longint x, longint y, bit last);
        point_t p;
        p.x = x[31:0];
        p.y = y[31:0];
        p.last = last;
        pending_points = {pending_points, p};
    endtask

    function automatic longint rand_value(bit narrow);
        if (narrow)
            return longint'($urandom_range(0, 2 * 2097152)) - 2097152;
        return longint'(signed'($urandom()));
    endfunction

    task automatic add_random_set(int len);
        bit     narrow;
        longint sl;
        longint x;
        narrow = $urandom_range(0, 3) != 0;
        sl = longint'($urandom_range(0, 8)) - 4;
        for (int i = 0; i < len; i++)
        begin
            x = rand_value(narrow);
            if (narrow && $urandom_range(0, 1))
                add_point(x, x * sl + longint'($urandom_range(0, 4096)) - 2048, i == len - 1);
            else
                add_point(x, rand_value(narrow), i == len - 1);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int budget;
        int len;
        rst_n = 1'b0;
        idle_on = 1'b1;
        set_dropped = 1'b0;
        // directed: tiny sets, flat x, extremes, clipped slope, dropped points
        add_point(32'sh7fffffff, -32'sh80000000, 1'b1);
        add_point(-32'sh80000000, 32'sh7fffffff, 1'b0);
        add_point(0, 0, 1'b1);
        for (int i = 0; i < 4; i++)
            add_point(-32'sh80000000, 65536 * i, i == 3);
        add_point(-32'sh80000000, -32'sh80000000, 1'b0);
        add_point(32'sh7fffffff, 32'sh7fffffff, 1'b0);
        add_point(0, -1, 1'b1);
        add_point(0, 0, 1'b0);
        add_point(1, 32'sh7fffffff, 1'b0);
        add_point(2, -32'sh80000000, 1'b1);
        for (int i = 0; i < 3; i++)
            add_point(65536 * i, 131072 * i + 65536, i == 2);
        for (int i = 0; i < NPTS + 3; i++)
            add_point(rand_value(1), rand_value(1), i == NPTS + 2);
        budget = 20;
        while (budget > 0)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            add_random_set(len);
            budget -= len;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_points.size() == 0 && !s_axis_tvalid);
        wait (expected_fits.size() == 0);
        repeat (400) @(posedge clk);
        $display("Sent %0d points in %0d sets, checked %0d fit results.",
                 points_sent, sets_closed, fits_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            out_taken <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            out_taken <= m_axis_tvalid && m_axis_tready;
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // predict on every accepted point
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            points_sent++;
            if (set_x.size() < NPTS)
            begin
                set_x = {set_x, longint'(signed'(s_axis_tdata[31:0]))};
                set_y = {set_y, longint'(signed'(s_axis_tdata[63:32]))};
            end
            else
            begin
                set_dropped = 1'b1;
            end
            if (s_axis_tlast)
                close_set();
        end
    end

    // check every accepted result
    always @(posedge clk)
    begin
        fit_out_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_fits.size() == 0)
            begin
                $error("unexpected result transaction");
                mismatches++;
            end
            else
            begin
                e = expected_fits.pop_front();
                fits_checked++;
                if (m_axis_tdata[31:0] !== e.fitted)
                begin
                    $error("fitted_value exp %h got %h", e.fitted, m_axis_tdata[31:0]);
                    mismatches++;
                end
                if (m_axis_tdata[63:32] !== e.residual)
                begin
                    $error("residual exp %h got %h", e.residual, m_axis_tdata[63:32]);
                    mismatches++;
                end
                if (m_axis_tdata[95:64] !== e.icpt)
                begin
                    $error("intercept exp %h got %h", e.icpt, m_axis_tdata[95:64]);
                    mismatches++;
                end
                if (m_axis_tdata[127:96] !== e.slope)
                begin
                    $error("slope exp %h got %h", e.slope, m_axis_tdata[127:96]);
                    mismatches++;
                end
                if (m_axis_tdata[159:128] !== e.mse)
                begin
                    $error("mean_sq_error exp %h got %h", e.mse, m_axis_tdata[159:128]);
                    mismatches++;
                end
                if (m_axis_tuser !== e.status)
                begin
                    $error("fit_status exp %0d got %0d", e.status, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $error("last_result exp %0d got %0d", e.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // drive points at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        point_t p;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
            send_gap = 0;
        end
        else if (!s_axis_tvalid || in_taken)
        begin
            if (in_taken)
            begin
                if (s_axis_tlast)
                    idle_on = $urandom_range(0, 3) != 0;
                send_gap = idle_on ? $urandom_range(0, 13) : 0;
            end
            if (send_gap > 0 || pending_points.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                p = pending_points.pop_front();
                s_axis_tdata <= {p.y, p.x};
                s_axis_tlast <= p.last;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // stall the result side at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_taken)
                recv_stall = idle_on ? $urandom_range(0, 13) : 0;
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire
